>>> rtl/core/gescl_pkg.sv
`timescale 1ns / 1ps
package gescl_pkg;
	localparam int MaxClusters = 64;
	localparam int CoordBits   = 12;
	localparam int IdxBits     = $clog2(MaxClusters);
	localparam int UsedBits    = $clog2(MaxClusters + 1);
	localparam int CountBits   = 16;
	localparam int SumBits     = 32;
	localparam int CfgIdxBits  = 3;
	localparam int CfgDataBits = 12;
	localparam logic [CountBits-1:0] CountMax = '1;

	typedef logic [CoordBits-1:0] coord_t;

	// Register indexes
	localparam logic [CfgIdxBits-1:0] RegLightLow  = 3'd0;
	localparam logic [CfgIdxBits-1:0] RegLightHigh = 3'd1;
	localparam logic [CfgIdxBits-1:0] RegDarkHigh  = 3'd2;
	localparam logic [CfgIdxBits-1:0] RegMinSpan   = 3'd3;
	localparam logic [CfgIdxBits-1:0] RegMaxSpan   = 3'd4;
	localparam logic [CfgIdxBits-1:0] RegEdgeSlack = 3'd5;
	localparam logic [CfgIdxBits-1:0] RegXTol      = 3'd6;
	localparam logic [CfgIdxBits-1:0] RegRowTol    = 3'd7;

	// Queue entry from front to back: a segment or a frame end
	typedef struct packed {
		logic   is_end;
		coord_t mid;
		coord_t row;
	} seg_cmd_t;

	typedef struct packed {
		logic [11:0] gap_column;
		logic        found;
		logic [15:0] winner_count;
		logic        table_overflow;
	} report_t;
endpackage

>>> rtl/core/gescl_front.sv
`timescale 1ns / 1ps
module gescl_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pix_valid,
	output logic                pix_ready,
	input  logic [7:0]          red,
	input  logic [7:0]          green,
	input  logic [7:0]          blue,
	input  gescl_pkg::coord_t   column,
	input  gescl_pkg::coord_t   row,
	input  logic                frame_last,
	input  logic [7:0]          light_low,
	input  logic [7:0]          light_high,
	input  logic [7:0]          dark_high,
	input  gescl_pkg::coord_t   min_span,
	input  gescl_pkg::coord_t   max_span,
	input  gescl_pkg::coord_t   edge_slack,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output gescl_pkg::seg_cmd_t cmd
);
	logic [1:0]        phase_q;
	gescl_pkg::coord_t start_q;
	logic              light, dark, x0, emit, gone;
	logic [1:0]        ph, ph_nxt;
	logic signed [gescl_pkg::CoordBits:0] span_d;
	logic [gescl_pkg::CoordBits:0] midsum;
	logic              acc;
	logic              end_pend_q;

	// Stall the pixel when it needs a queue slot that is not free or a frame end is owed
	assign pix_ready = !end_pend_q && (cmd_ready || !(emit || frame_last));
	assign acc = pix_valid && pix_ready;

	// Classify and track
	always_comb begin
		x0 = (column == '0);
		ph = x0 ? 2'd0 : phase_q;
		light = red > light_low && green > light_low && blue > light_low &&
			red < light_high && green < light_high && blue < light_high;
		dark = red < dark_high && green < dark_high && blue < dark_high;
		span_d = $signed({1'b0, column}) - $signed({1'b0, start_q});
		gone = span_d > $signed({1'b0, edge_slack});
		emit = 1'b0;
		ph_nxt = ph;
		if (light) begin
			if (ph == 2'd0) ph_nxt = 2'd1;
			else if (ph == 2'd2) begin
				if (span_d >= $signed({1'b0, min_span}) &&
					span_d <= $signed({1'b0, max_span})) begin
					emit = 1'b1;
					ph_nxt = 2'd0;
				end
			end else if (gone) ph_nxt = 2'd0;
		end else if (dark) begin
			if (ph == 2'd1) ph_nxt = 2'd2;
		end else if (gone) ph_nxt = 2'd0;
		midsum = {1'b0, start_q} + {1'b0, column};
	end

	// Issue segment or frame end
	assign cmd_valid = end_pend_q || (pix_valid && (emit || frame_last));
	always_comb begin
		cmd.is_end = end_pend_q || !emit;
		cmd.mid    = midsum[gescl_pkg::CoordBits:1];
		cmd.row    = row;
	end

	// Advance tracker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			start_q <= '0;
		end else if (acc) begin
			if (frame_last) begin
				phase_q <= 2'd0;
				start_q <= '0;
			end else begin
				phase_q <= ph_nxt;
				if (light && ph == 2'd0) start_q <= column;
			end
		end
	end

	// A frame end that closes a segment issues the segment, then owes the frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_pend_q <= 1'b0;
		end else if (end_pend_q) begin
			if (cmd_ready) end_pend_q <= 1'b0;
		end else if (acc && emit && frame_last) begin
			end_pend_q <= 1'b1;
		end
	end
endmodule

>>> rtl/core/gescl_queue.sv
`timescale 1ns / 1ps
module gescl_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  gescl_pkg::seg_cmd_t in_cmd,
	output logic                out_valid,
	input  logic                out_ready,
	output gescl_pkg::seg_cmd_t out_cmd
);
	gescl_pkg::seg_cmd_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic wr, rd;

	assign in_ready  = cnt_q != 3'd4;
	assign out_valid = cnt_q != 3'd0;
	assign out_cmd   = mem_q[rp_q];
	assign wr = in_valid && in_ready;
	assign rd = out_valid && out_ready;

	// Hold entries
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= in_cmd;
	end

	// Advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, wr} - {2'd0, rd};
		end
	end
endmodule

>>> rtl/core/gescl_back.sv
`timescale 1ns / 1ps
module gescl_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  gescl_pkg::seg_cmd_t cmd,
	input  gescl_pkg::coord_t   x_tol,
	input  gescl_pkg::coord_t   row_tol,
	output logic                rep_valid,
	input  logic                rep_ready,
	output gescl_pkg::report_t  rep
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001, S_SCAN = 6'b000010, S_DIV = 6'b000100,
		S_OPEN = 6'b001000, S_BEST = 6'b010000, S_OUT = 6'b100000
	} st_t;
	localparam int IB = gescl_pkg::IdxBits;
	localparam int UB = gescl_pkg::UsedBits;
	localparam int CB = gescl_pkg::CoordBits;
	localparam int NB = gescl_pkg::CountBits;
	localparam int SB = gescl_pkg::SumBits;

	st_t st_q;
	// Cluster store: mean, sum, count, row_min, row_max packed per entry
	typedef struct packed {
		logic [CB-1:0] mean;
		logic [SB-1:0] sum;
		logic [NB-1:0] count;
		logic [CB-1:0] rmin;
		logic [CB-1:0] rmax;
	} ent_t;
	ent_t mem_q [gescl_pkg::MaxClusters];
	ent_t rd_q, wr_d, upd_d;
	logic            we;
	logic [IB-1:0]   ra, wa;
	logic [UB-1:0]   used_q, i_q;
	logic            ovf_q, rdv_q;
	gescl_pkg::seg_cmd_t c_q;
	logic [IB-1:0]   hit_q;
	ent_t            upd_q;
	logic [SB-1:0]   rem_q, quo_q;
	logic [5:0]      dstep_q;
	logic [NB-1:0]   bcnt_q;
	logic [CB-1:0]   bmean_q;
	logic [CB:0]     dx;
	logic [CB+1:0]   lo, hi;
	logic            match, last_rd;
	logic [SB:0]     trial;

	assign cmd_ready = (st_q == S_IDLE);
	assign rep_valid = (st_q == S_OUT);
	assign last_rd   = (i_q >= used_q);

	// Registered read port and write port
	always_ff @(posedge clk) begin
		rd_q <= mem_q[ra];
		if (we) mem_q[wa] <= wr_d;
	end

	always_comb begin
		dx = (rd_q.mean >= c_q.mid) ? {1'b0, rd_q.mean - c_q.mid} : {1'b0, c_q.mid - rd_q.mean};
		lo = {2'b0, c_q.row} + {2'b0, row_tol};
		hi = {2'b0, rd_q.rmax} + {2'b0, row_tol};
		match = dx <= {1'b0, x_tol} && lo >= {2'b0, rd_q.rmin} && {2'b0, c_q.row} <= hi;
		trial = {rem_q, quo_q[SB-1]} - {{(SB-NB+1){1'b0}}, upd_q.count};
		// Entry after the segment joins: widen rows, grow unless saturated
		upd_d = rd_q;
		if (c_q.row < rd_q.rmin) upd_d.rmin = c_q.row;
		if (c_q.row > rd_q.rmax) upd_d.rmax = c_q.row;
		if (rd_q.count != gescl_pkg::CountMax) begin
			upd_d.count = rd_q.count + 1'b1;
			upd_d.sum = rd_q.sum + {{(SB-CB){1'b0}}, c_q.mid};
		end
		ra = i_q[IB-1:0];
		we = 1'b0;
		wa = hit_q;
		wr_d = upd_q;
		if (st_q == S_DIV && dstep_q == 6'd32) begin
			we = 1'b1;
			wr_d.mean = quo_q[CB-1:0];
		end else if (st_q == S_OPEN) begin
			we = 1'b1;
			wa = used_q[IB-1:0];
			wr_d.mean = c_q.mid; wr_d.sum = {{(SB-CB){1'b0}}, c_q.mid};
			wr_d.count = {{(NB-1){1'b0}}, 1'b1}; wr_d.rmin = c_q.row; wr_d.rmax = c_q.row;
		end
	end

	// Sequence one command: scan table, then divide for mean or open a cluster; or pick winner and hold the report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; used_q <= '0; ovf_q <= 1'b0; i_q <= '0; rdv_q <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: if (cmd_valid) begin
					c_q <= cmd; i_q <= '0; rdv_q <= 1'b0;
					bcnt_q <= '0; bmean_q <= '0;
					st_q <= cmd.is_end ? S_BEST : S_SCAN;
				end
				S_SCAN: begin
					rdv_q <= 1'b1;
					i_q <= i_q + 1'b1;
					if (rdv_q && i_q <= used_q && match) begin
						hit_q <= ra - 1'b1;
						upd_q <= upd_d;
						if (rd_q.count != gescl_pkg::CountMax) quo_q <= upd_d.sum;
						else quo_q <= {{(SB-CB){1'b0}}, rd_q.mean};
						rem_q <= '0;
						dstep_q <= (rd_q.count != gescl_pkg::CountMax) ? 6'd0 : 6'd32;
						st_q <= S_DIV;
					end else if (rdv_q && i_q > used_q) begin
						st_q <= S_IDLE;
						if (used_q == UB'(gescl_pkg::MaxClusters)) ovf_q <= 1'b1;
						else st_q <= S_OPEN;
					end else if (i_q == used_q && used_q == '0) begin
						st_q <= (used_q == UB'(gescl_pkg::MaxClusters)) ? S_IDLE : S_OPEN;
					end
				end
				S_DIV: begin
					if (dstep_q == 6'd32) st_q <= S_IDLE;
					else begin
						dstep_q <= dstep_q + 6'd1;
						if (!trial[SB]) begin
							rem_q <= trial[SB-1:0];
							quo_q <= {quo_q[SB-2:0], 1'b1};
						end else begin
							rem_q <= {rem_q[SB-2:0], quo_q[SB-1]};
							quo_q <= {quo_q[SB-2:0], 1'b0};
						end
					end
				end
				S_OPEN: begin used_q <= used_q + 1'b1; st_q <= S_IDLE; end
				S_BEST: begin
					rdv_q <= 1'b1;
					i_q <= i_q + 1'b1;
					if (rdv_q && (i_q - 1'b1) < used_q && rd_q.count > bcnt_q) begin
						bcnt_q <= rd_q.count; bmean_q <= rd_q.mean;
					end
					if (rdv_q && last_rd) st_q <= S_OUT;
				end
				S_OUT: if (rep_ready) begin
					used_q <= '0; ovf_q <= 1'b0; st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		rep.gap_column = bmean_q;
		rep.found = used_q != '0;
		rep.winner_count = bcnt_q;
		rep.table_overflow = ovf_q;
	end
endmodule

>>> rtl/core/gap_edge_segment_cluster_locator_core.sv
`timescale 1ns / 1ps
// Throughput: one pixel per cycle while the segment queue has room and no frame end is owed;
// a pixel that closes a segment and ends the frame issues the segment, then the frame end.
// A segment holds the back end while it scans the table, then while it opens a cluster (it is
// dropped if the table is full) or, on joining an unsaturated cluster, while the divider forms
// the new mean. The report goes valid after the back end takes the frame end and scans the
// table. Reset (arst_n low, asynchronous) empties the table and restores register defaults.
module gap_edge_segment_cluster_locator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // red, green, blue, column, row
	input  logic        s_axis_tlast,  // frame_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // gap_column, found, winner_count, table_overflow
	input  logic        cfg_we,
	input  logic [gescl_pkg::CfgIdxBits-1:0]  cfg_index,
	input  logic [gescl_pkg::CfgDataBits-1:0] cfg_data
);
	logic [7:0] ll_q, lh_q, dh_q;
	gescl_pkg::coord_t mins_q, maxs_q, slack_q, xt_q, rt_q;
	logic qv, qr, bv, br;
	gescl_pkg::seg_cmd_t qc, bc;
	gescl_pkg::report_t rep;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ll_q <= 8'd115; lh_q <= 8'd220; dh_q <= 8'd110;
			mins_q <= 12'd30; maxs_q <= 12'd120; slack_q <= 12'd5;
			xt_q <= 12'd3; rt_q <= 12'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				gescl_pkg::RegLightLow:  ll_q <= cfg_data[7:0];
				gescl_pkg::RegLightHigh: lh_q <= cfg_data[7:0];
				gescl_pkg::RegDarkHigh:  dh_q <= cfg_data[7:0];
				gescl_pkg::RegMinSpan:   mins_q <= cfg_data;
				gescl_pkg::RegMaxSpan:   maxs_q <= cfg_data;
				gescl_pkg::RegEdgeSlack: slack_q <= cfg_data;
				gescl_pkg::RegXTol:      xt_q <= cfg_data;
				gescl_pkg::RegRowTol:    rt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	gescl_front u_front (
		.clk, .arst_n, .pix_valid(s_axis_tvalid), .pix_ready(s_axis_tready),
		.red(s_axis_tdata[7:0]), .green(s_axis_tdata[15:8]), .blue(s_axis_tdata[23:16]),
		.column(s_axis_tdata[35:24]), .row(s_axis_tdata[47:36]), .frame_last(s_axis_tlast),
		.light_low(ll_q), .light_high(lh_q), .dark_high(dh_q),
		.min_span(mins_q), .max_span(maxs_q), .edge_slack(slack_q),
		.cmd_valid(qv), .cmd_ready(qr), .cmd(qc)
	);

	gescl_queue u_queue (
		.clk, .arst_n, .in_valid(qv), .in_ready(qr), .in_cmd(qc),
		.out_valid(bv), .out_ready(br), .out_cmd(bc)
	);

	gescl_back u_back (
		.clk, .arst_n, .cmd_valid(bv), .cmd_ready(br), .cmd(bc),
		.x_tol(xt_q), .row_tol(rt_q),
		.rep_valid(m_axis_tvalid), .rep_ready(m_axis_tready), .rep
	);

	assign m_axis_tdata = {2'b0, rep.table_overflow, rep.winner_count, rep.found, rep.gap_column};
endmodule

>>> rtl/core/gescl_checker.sv
`timescale 1ns / 1ps
module gescl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);
	// Hold a stalled report
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("report changed while stalled");
	// No cluster means zero mean and count
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[12] |-> m_axis_tdata[11:0] == 12'd0 &&
		m_axis_tdata[28:13] == 16'd0) else $error("empty report carries data");
	// A found cluster has at least one segment
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[12] |-> m_axis_tdata[28:13] != 16'd0)
		else $error("found with zero count");
endmodule

bind gap_edge_segment_cluster_locator_core gescl_checker u_chk (
	.clk, .arst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

>>> sim/gap_edge_segment_cluster_locator_core_test.sv
`timescale 1ns / 1ps
module gap_edge_segment_cluster_locator_core_test;
	localparam int LongHold    = 2000;
	localparam int SettleCyc   = 300;
	localparam int CycleLimit  = 2000000;
	localparam int TableDepth  = 64;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;   // red, green, blue, column, row
	logic        s_axis_tlast;   // frame_last
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // gap_column, found, winner_count, table_overflow
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [11:0] cfg_data;

	gap_edge_segment_cluster_locator_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predictor copy of the registers
	logic [7:0]  thr_light_low, thr_light_high, thr_dark_high;
	logic [11:0] span_min, span_max, slack, x_tol, row_tol;

	// Predictor copy of the tracker and cluster table
	int          scan_state;
	logic [11:0] run_start;
	logic [11:0] cl_mean [TableDepth];
	longint      cl_sum [TableDepth];
	int          cl_count [TableDepth];
	int          cl_row_lo [TableDepth];
	int          cl_row_hi [TableDepth];
	int          cl_used;
	bit          cl_overflow;

	gescl_pkg::report_t pending_reports[$];
	int          error_count;
	bit          idle_on;
	int          hold_request;
	longint      cycle_count;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("gap_edge_segment_cluster_locator_core_test: errors");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic void clear_table();
		cl_used = 0;
		cl_overflow = 0;
		scan_state = 0;
		run_start = '0;
	endfunction

	function automatic void join_segment(int mid, int y);
		int d;
		for (int i = 0; i < cl_used; i++) begin
			d = int'(cl_mean[i]) - mid;
			if (d < 0) d = -d;
			if (d > int'(x_tol)) continue;
			if (y < cl_row_lo[i] - int'(row_tol) || y > cl_row_hi[i] + int'(row_tol)) continue;
			// Saturated clusters only widen their row range
			if (cl_count[i] < 65535) begin
				cl_count[i]++;
				cl_sum[i] += mid;
				cl_mean[i] = 12'(cl_sum[i] / cl_count[i]);
			end
			if (y < cl_row_lo[i]) cl_row_lo[i] = y;
			if (y > cl_row_hi[i]) cl_row_hi[i] = y;
			return;
		end
		if (cl_used >= TableDepth) begin
			cl_overflow = 1;
			return;
		end
		cl_count[cl_used] = 1;
		cl_sum[cl_used] = mid;
		cl_mean[cl_used] = 12'(mid);
		cl_row_lo[cl_used] = y;
		cl_row_hi[cl_used] = y;
		cl_used++;
	endfunction

	// Advance the predictor by one pixel; queue a report on frame end
	function automatic void track_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic [11:0] x, logic [11:0] y, logic last);
		bit      is_light, is_dark;
		int      span_d;
		int      best_count, best_mean;
		gescl_pkg::report_t rep;
		if (x == 0) scan_state = 0;
		is_light = r > thr_light_low && g > thr_light_low && b > thr_light_low &&
			r < thr_light_high && g < thr_light_high && b < thr_light_high;
		is_dark = r < thr_dark_high && g < thr_dark_high && b < thr_dark_high;
		span_d = int'(x) - int'(run_start);
		if (is_light) begin
			if (scan_state == 0) begin
				scan_state = 1;
				run_start = x;
			end else if (scan_state == 2) begin
				if (span_d >= int'(span_min) && span_d <= int'(span_max)) begin
					join_segment((int'(run_start) + int'(x)) / 2, int'(y));
					scan_state = 0;
				end
			end else if (span_d > int'(slack)) begin
				scan_state = 0;
			end
		end else if (is_dark) begin
			if (scan_state == 1) scan_state = 2;
		end else if (span_d > int'(slack)) begin
			scan_state = 0;
		end
		if (last) begin
			best_count = 0;
			best_mean = 0;
			for (int i = 0; i < cl_used; i++) begin
				if (cl_count[i] > best_count) begin
					best_count = cl_count[i];
					best_mean = cl_mean[i];
				end
			end
			rep.gap_column = 12'(best_mean);
			rep.found = cl_used > 0;
			rep.winner_count = 16'(best_count);
			rep.table_overflow = cl_overflow;
			pending_reports = {pending_reports, rep};
			clear_table();
		end
	endfunction

	// Offer one pixel and wait for its transaction
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic [11:0] x, input logic [11:0] y, input logic last);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(0, 9)) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {y, x, b, g, r};
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		track_pixel(r, g, b, x, y, last);
	endtask

	// Drop valid and wait until every report has come back
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		s_axis_tlast <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SettleCyc) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			gescl_pkg::RegLightLow:  thr_light_low = val[7:0];
			gescl_pkg::RegLightHigh: thr_light_high = val[7:0];
			gescl_pkg::RegDarkHigh:  thr_dark_high = val[7:0];
			gescl_pkg::RegMinSpan:   span_min = val;
			gescl_pkg::RegMaxSpan:   span_max = val;
			gescl_pkg::RegEdgeSlack: slack = val;
			gescl_pkg::RegXTol:      x_tol = val;
			default:                 row_tol = val;
		endcase
	endtask

	task automatic write_all(input logic [7:0] ll, input logic [7:0] lh, input logic [7:0] dh,
			input logic [11:0] mn, input logic [11:0] mx, input logic [11:0] sl,
			input logic [11:0] xt, input logic [11:0] rt);
		write_reg(gescl_pkg::RegLightLow, ll);
		write_reg(gescl_pkg::RegLightHigh, lh);
		write_reg(gescl_pkg::RegDarkHigh, dh);
		write_reg(gescl_pkg::RegMinSpan, mn);
		write_reg(gescl_pkg::RegMaxSpan, mx);
		write_reg(gescl_pkg::RegEdgeSlack, sl);
		write_reg(gescl_pkg::RegXTol, xt);
		write_reg(gescl_pkg::RegRowTol, rt);
	endtask

	function automatic logic [7:0] light_level();
		if (int'(thr_light_high) > int'(thr_light_low) + 1)
			return 8'($urandom_range(thr_light_low + 1, thr_light_high - 1));
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] dark_level();
		if (thr_dark_high > 0) return 8'($urandom_range(0, thr_dark_high - 1));
		return 8'($urandom);
	endfunction

	// Light at x0, dark at x0 + 1, light at x1
	task automatic send_segment(input logic [11:0] x0, input logic [11:0] x1, input logic [11:0] y,
			input logic last);
		send_pixel(light_level(), light_level(), light_level(), x0, y, 1'b0);
		send_pixel(dark_level(), dark_level(), dark_level(), x0 + 12'd1, y, 1'b0);
		send_pixel(light_level(), light_level(), light_level(), x1, y, last);
	endtask

	task automatic test_default_tracker();
		// Span at the lower and upper bound; the two lower-bound segments join one cluster
		send_segment(12'd0, 12'd30, 12'd0, 1'b0);
		send_segment(12'd0, 12'd30, 12'd1, 1'b0);
		send_segment(12'd100, 12'd220, 12'd2, 1'b0);
		// Span just outside either bound keeps the tracker waiting, then a row restart
		send_segment(12'd0, 12'd29, 12'd5, 1'b0);
		send_pixel(8'd150, 8'd150, 8'd150, 12'd150, 12'd5, 1'b0);
		send_segment(12'd0, 12'd121, 12'd6, 1'b0);
		// Column moving backwards gives a negative span
		send_segment(12'd200, 12'd100, 12'd7, 1'b0);
		// Light too far after the start, then a neutral pixel beyond the slack
		send_pixel(8'd150, 8'd150, 8'd150, 12'd0, 12'd8, 1'b0);
		send_pixel(8'd150, 8'd150, 8'd150, 12'd9, 12'd8, 1'b0);
		send_pixel(8'd150, 8'd150, 8'd150, 12'd20, 12'd8, 1'b0);
		send_pixel(8'd255, 8'd0, 8'd255, 12'd40, 12'd8, 1'b0);
		// Channel and coordinate extremes
		send_pixel(8'd0, 8'd0, 8'd0, 12'd4095, 12'd4095, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 12'd4094, 12'd4095, 1'b1);
		// Frame with no cluster at all
		send_pixel(8'd0, 8'd255, 8'd0, 12'd0, 12'd0, 1'b1);
		drain();
	endtask

	task automatic test_min_above_max();
		write_reg(gescl_pkg::RegMinSpan, 12'd50);
		write_reg(gescl_pkg::RegMaxSpan, 12'd40);
		send_segment(12'd0, 12'd45, 12'd0, 1'b0);
		send_segment(12'd0, 12'd40, 12'd1, 1'b0);
		send_segment(12'd0, 12'd50, 12'd2, 1'b1);
		drain();
	endtask

	task automatic test_table_overflow();
		write_all(8'd115, 8'd220, 8'd110, 12'd1, 12'd4095, 12'd5, 12'd0, 12'd0);
		for (int i = 0; i < TableDepth + 3; i++)
			send_segment(12'd0, 12'(2 + 2 * i), 12'(4 * i), i == TableDepth + 2);
		drain();
	endtask

	task automatic test_backpressure();
		write_all(8'd115, 8'd220, 8'd110, 12'd2, 12'd20, 12'd3, 12'd3, 12'd3);
		hold_request = LongHold;
		for (int f = 0; f < 30; f++) begin
			if (f % 3 == 0) send_segment(12'd0, 12'd10, 12'(f), 1'b0);
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 12'($urandom), 12'(f), 1'b1);
		end
		drain();
	endtask

	task automatic random_frames(input int n_items);
		int   sent;
		int   x0, y;
		logic last;
		sent = 0;
		while (sent < n_items) begin
			last = $urandom_range(0, 11) == 0 || sent + 4 >= n_items;
			if ($urandom_range(0, 4) == 0) begin
				// Noise pixel anywhere
				send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 12'($urandom),
					12'($urandom), last);
				sent++;
			end else begin
				x0 = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 60);
				y = $urandom_range(0, 12);
				send_segment(12'(x0), 12'(x0 + $urandom_range(0, 24)), 12'(y), last);
				sent += 3;
			end
		end
		drain();
	endtask

	task automatic test_random_settings();
		write_all(8'd115, 8'd220, 8'd110, 12'd2, 12'd20, 12'd3, 12'd3, 12'd3);
		random_frames(40);
		write_all(8'd0, 8'd255, 8'd255, 12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
		random_frames(30);
		write_all(8'd255, 8'd0, 8'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
		random_frames(20);
		write_all(8'd60, 8'd200, 8'd128, 12'd4, 12'd16, 12'd1, 12'd1, 12'd0);
		random_frames(30);
		// Last part runs without idling on either side
		idle_on = 0;
		write_all(8'd100, 8'd240, 8'd90, 12'd3, 12'd22, 12'd2, 12'd4, 12'd2);
		random_frames(40);
	endtask

	// Receiver: random stalls plus the requested long hold-off
	initial begin
		int hold_left;
		hold_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end else if (hold_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
				hold_left = $urandom_range(1, 10);
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Compare each report transaction with the oldest prediction
	always @(posedge clk) begin
		gescl_pkg::report_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_reports.size() == 0) begin
				report_mismatch("unexpected report", m_axis_tdata, 0);
			end else begin
				want = pending_reports.pop_front();
				if (m_axis_tdata[11:0] != want.gap_column)
					report_mismatch("gap_column", m_axis_tdata[11:0], want.gap_column);
				if (m_axis_tdata[12] != want.found)
					report_mismatch("found", m_axis_tdata[12], want.found);
				if (m_axis_tdata[28:13] != want.winner_count)
					report_mismatch("winner_count", m_axis_tdata[28:13], want.winner_count);
				if (m_axis_tdata[29] != want.table_overflow)
					report_mismatch("table_overflow", m_axis_tdata[29], want.table_overflow);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		error_count = 0;
		hold_request = 0;
		cycle_count = 0;
		idle_on = 1;
		thr_light_low = 8'd115;
		thr_light_high = 8'd220;
		thr_dark_high = 8'd110;
		span_min = 12'd30;
		span_max = 12'd120;
		slack = 12'd5;
		x_tol = 12'd3;
		row_tol = 12'd3;
		clear_table();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_default_tracker();
		test_min_above_max();
		test_table_overflow();
		test_backpressure();
		test_random_settings();

		if (pending_reports.size() != 0)
			report_mismatch("reports left over", pending_reports.size(), 0);
		if (error_count == 0)
			$display("gap_edge_segment_cluster_locator_core_test: clean");
		else
			$display("gap_edge_segment_cluster_locator_core_test: errors");
		$finish;
	end
endmodule
